// ===== hw/rtl/rcsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record chunk stream parser package
// Shared types, result codes and sizing constants for the parser front end,
// the result queue and the result serializer.
// ----------------------------------------------------------------------------
package rcsp_pkg;

    // Parameter words that every record must carry (legal range 1 to 64).
    localparam int unsigned PARAM_COUNT = 8;
    localparam logic [5:0]  PARAM_LAST  = 6'(PARAM_COUNT - 1);
    localparam logic [31:0] COUNT_WORD  = 32'(PARAM_COUNT);

    // Zero bytes held back at a record boundary saturate here.
    localparam logic [3:0]  ZERO_SAT    = 4'd9;
    localparam logic [23:0] REC_MAX     = 24'hFF_FFFF;

    // Up to four results come out of one input byte.
    localparam int unsigned MAX_RES     = 4;
    localparam int unsigned RES_IDX_W   = $clog2(MAX_RES);
    localparam int unsigned RES_CNT_W   = RES_IDX_W + 1;

    // Result queue between the parser and the serializer.
    localparam int unsigned Q_DEPTH     = 4;
    localparam int unsigned Q_AW        = $clog2(Q_DEPTH);

    typedef enum logic [2:0] {
        KIND_MARKER    = 3'd0,
        KIND_NAME_BYTE = 3'd1,
        KIND_NAME_END  = 3'd2,
        KIND_PARAM     = 3'd3,
        KIND_OK        = 3'd4,
        KIND_ERROR     = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_MISSING_MARKER = 3'd1,
        ERR_UNTERM_NAME    = 3'd2,
        ERR_MISSING_COUNT  = 3'd3,
        ERR_WRONG_COUNT    = 3'd4,
        ERR_TRUNC_PARAMS   = 3'd5
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] word;
        logic [5:0]  param_index;
        logic [23:0] record_index;
        err_t        error_code;
        logic [31:0] error_offset;
        logic        likely_valid;
    } result_t;

    // All results caused by one accepted byte, in order.
    typedef struct packed {
        logic [RES_CNT_W-1:0]        cnt;
        result_t [MAX_RES-1:0]       res;
    } group_t;

endpackage

// ===== hw/rtl/rcsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record chunk parser front end
// Takes one byte per cycle while the queue has room, updates the record parse
// state and hands the results caused by that byte to the queue as one group.
// ----------------------------------------------------------------------------
module rcsp_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_last,
    output logic                  push_valid,
    input  logic                  push_ready,
    output rcsp_pkg::group_t      push_group
);

    typedef enum logic [2:0] {
        PH_BOUND = 3'd0,
        PH_MARK  = 3'd1,
        PH_NAME  = 3'd2,
        PH_COUNT = 3'd3,
        PH_PARAM = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  fbc_reg, fbc_next;
    logic [31:0] wb_reg, wb_next;
    logic [31:0] off_reg, off_next;
    logic [31:0] fs_reg, fs_next;
    logic [5:0]  slot_reg, slot_next;
    logic [23:0] rs_reg, rs_next;
    logic [3:0]  pend_reg, pend_next;
    logic        named_reg, named_next;
    logic        nonempty_reg, nonempty_next;
    logic        halted_reg, halted_next;

    logic                  accept;
    rcsp_pkg::group_t      grp;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [2:0] k);
        logic [32:0] s;
        s = {1'b0, a} + {30'b0, k};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic rcsp_pkg::result_t mk_res(
        input rcsp_pkg::kind_t kind,
        input logic [31:0]     word,
        input logic [5:0]      pidx,
        input logic [23:0]     rec,
        input rcsp_pkg::err_t  code,
        input logic [31:0]     eoff,
        input logic            likely
    );
        rcsp_pkg::result_t r;
        r.kind         = kind;
        r.word         = word;
        r.param_index  = pidx;
        r.record_index = rec;
        r.error_code   = code;
        r.error_offset = eoff;
        r.likely_valid = likely;
        return r;
    endfunction

    assign in_ready = push_ready;
    assign accept   = in_valid && in_ready;

    always_comb begin : parse_c
        phase_t                              p;
        logic [1:0]                          fbc;
        logic [31:0]                         wb;
        logic [31:0]                         fs;
        logic [5:0]                          slot;
        logic [23:0]                         rs;
        logic [3:0]                          pend;
        logic                                nn;
        logic                                an;
        logic                                halt;
        logic [31:0]                         cur;
        logic [31:0]                         nxt;
        logic [31:0]                         base;
        logic [rcsp_pkg::RES_CNT_W-1:0]      n;
        rcsp_pkg::result_t [rcsp_pkg::MAX_RES-1:0] res;

        p    = phase_reg;
        fbc  = fbc_reg;
        wb   = wb_reg;
        fs   = fs_reg;
        slot = slot_reg;
        rs   = rs_reg;
        pend = pend_reg;
        nn   = nonempty_reg;
        an   = named_reg;
        halt = halted_reg;
        cur  = off_reg;
        nxt  = sat_add(off_reg, 3'd1);
        base = fs_reg;
        n    = '0;
        res  = '0;
        off_next = off_reg;

        if (!halted_reg) begin
            off_next = nxt;
            if (p == PH_BOUND && in_byte == 8'd0) begin
                if (pend == 4'd0) begin
                    fs = cur;
                end
                if (pend < rcsp_pkg::ZERO_SAT) begin
                    pend = pend + 4'd1;
                end
            end else begin
                // Held zeros turn out to be record bytes: replay them in one go.
                if (p == PH_BOUND && pend != 4'd0) begin
                    if (pend >= 4'd4) begin
                        res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_MARKER,
                            32'd0, 6'd0, rs, rcsp_pkg::ERR_NONE, 32'd0, 1'b0);
                        n = n + (rcsp_pkg::RES_CNT_W)'(1);
                    end
                    if (pend >= 4'd5) begin
                        res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_NAME_END,
                            32'd0, 6'd0, rs, rcsp_pkg::ERR_NONE, 32'd0, 1'b0);
                        n  = n + (rcsp_pkg::RES_CNT_W)'(1);
                        an = 1'b0;
                    end
                    if (pend >= rcsp_pkg::ZERO_SAT) begin
                        res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_ERROR,
                            32'd0, 6'd0, rs, rcsp_pkg::ERR_WRONG_COUNT,
                            sat_add(base, 3'd5), 1'b0);
                        n    = n + (rcsp_pkg::RES_CNT_W)'(1);
                        halt = 1'b1;
                    end
                    // The word buffer is refilled before any field completes, so
                    // the shifted-out bits need not be tracked.
                    wb = 32'd0;
                    if (pend < 4'd4) begin
                        p   = PH_MARK;
                        fbc = pend[1:0];
                        fs  = base;
                    end else if (pend == 4'd4) begin
                        p   = PH_NAME;
                        fbc = 2'd0;
                        fs  = sat_add(base, 3'd4);
                        nn  = 1'b0;
                    end else begin
                        p   = PH_COUNT;
                        fbc = 2'(pend - 4'd5);
                        fs  = sat_add(base, 3'd5);
                    end
                    pend = 4'd0;
                end

                if (!halt) begin
                    if (p == PH_BOUND) begin
                        fs  = cur;
                        fbc = 2'd0;
                        p   = PH_MARK;
                    end
                    unique case (p)
                        PH_MARK: begin
                            wb  = {in_byte, wb[31:8]};
                            fbc = fbc + 2'd1;
                            if (fbc == 2'd0) begin
                                res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(
                                    rcsp_pkg::KIND_MARKER, wb, 6'd0, rs,
                                    rcsp_pkg::ERR_NONE, 32'd0, 1'b0);
                                n  = n + (rcsp_pkg::RES_CNT_W)'(1);
                                p  = PH_NAME;
                                fs = nxt;
                                nn = 1'b0;
                            end
                        end
                        PH_NAME: begin
                            if (in_byte != 8'd0) begin
                                nn = 1'b1;
                                res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(
                                    rcsp_pkg::KIND_NAME_BYTE, {24'd0, in_byte}, 6'd0, rs,
                                    rcsp_pkg::ERR_NONE, 32'd0, 1'b0);
                                n = n + (rcsp_pkg::RES_CNT_W)'(1);
                            end else begin
                                res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(
                                    rcsp_pkg::KIND_NAME_END, 32'd0, 6'd0, rs,
                                    rcsp_pkg::ERR_NONE, 32'd0, 1'b0);
                                n = n + (rcsp_pkg::RES_CNT_W)'(1);
                                if (!nn) begin
                                    an = 1'b0;
                                end
                                p   = PH_COUNT;
                                fs  = nxt;
                                fbc = 2'd0;
                            end
                        end
                        PH_COUNT: begin
                            wb  = {in_byte, wb[31:8]};
                            fbc = fbc + 2'd1;
                            if (fbc == 2'd0) begin
                                if (wb != rcsp_pkg::COUNT_WORD) begin
                                    res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(
                                        rcsp_pkg::KIND_ERROR, 32'd0, 6'd0, rs,
                                        rcsp_pkg::ERR_WRONG_COUNT, fs, 1'b0);
                                    n    = n + (rcsp_pkg::RES_CNT_W)'(1);
                                    halt = 1'b1;
                                end else begin
                                    p    = PH_PARAM;
                                    slot = 6'd0;
                                    fs   = nxt;
                                end
                            end
                        end
                        PH_PARAM: begin
                            wb  = {in_byte, wb[31:8]};
                            fbc = fbc + 2'd1;
                            if (fbc == 2'd0) begin
                                res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(
                                    rcsp_pkg::KIND_PARAM, wb, slot, rs,
                                    rcsp_pkg::ERR_NONE, 32'd0, 1'b0);
                                n  = n + (rcsp_pkg::RES_CNT_W)'(1);
                                fs = nxt;
                                if (slot >= rcsp_pkg::PARAM_LAST) begin
                                    if (rs != rcsp_pkg::REC_MAX) begin
                                        rs = rs + 24'd1;
                                    end
                                    slot = 6'd0;
                                    p    = PH_BOUND;
                                end else begin
                                    slot = slot + 6'd1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            if (in_last && !halt) begin
                unique case (p)
                    PH_BOUND: res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_OK,
                        32'd0, 6'd0, rs, rcsp_pkg::ERR_NONE, 32'd0,
                        (rs != 24'd0) && an);
                    PH_MARK:  res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_ERROR,
                        32'd0, 6'd0, rs, rcsp_pkg::ERR_MISSING_MARKER, fs, 1'b0);
                    PH_NAME:  res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_ERROR,
                        32'd0, 6'd0, rs, rcsp_pkg::ERR_UNTERM_NAME, fs, 1'b0);
                    PH_COUNT: res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_ERROR,
                        32'd0, 6'd0, rs, rcsp_pkg::ERR_MISSING_COUNT, fs, 1'b0);
                    default:  res[n[rcsp_pkg::RES_IDX_W-1:0]] = mk_res(rcsp_pkg::KIND_ERROR,
                        32'd0, 6'd0, rs, rcsp_pkg::ERR_TRUNC_PARAMS, fs, 1'b0);
                endcase
                n    = n + (rcsp_pkg::RES_CNT_W)'(1);
                halt = 1'b1;
            end
        end

        phase_next    = p;
        fbc_next      = fbc;
        wb_next       = wb;
        fs_next       = fs;
        slot_next     = slot;
        rs_next       = rs;
        pend_next     = pend;
        nonempty_next = nn;
        named_next    = an;
        halted_next   = halt;

        // The chunk's last byte always returns the parser to its start state.
        if (in_last) begin
            phase_next    = PH_BOUND;
            fbc_next      = 2'd0;
            wb_next       = 32'd0;
            off_next      = 32'd0;
            fs_next       = 32'd0;
            slot_next     = 6'd0;
            rs_next       = 24'd0;
            pend_next     = 4'd0;
            nonempty_next = 1'b0;
            named_next    = 1'b1;
            halted_next   = 1'b0;
        end

        grp.cnt = n;
        grp.res = res;
    end

    assign push_valid = accept && (grp.cnt != '0);
    assign push_group = grp;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_BOUND;
            fbc_reg      <= 2'd0;
            wb_reg       <= 32'd0;
            off_reg      <= 32'd0;
            fs_reg       <= 32'd0;
            slot_reg     <= 6'd0;
            rs_reg       <= 24'd0;
            pend_reg     <= 4'd0;
            named_reg    <= 1'b1;
            nonempty_reg <= 1'b0;
            halted_reg   <= 1'b0;
        end else if (accept) begin
            phase_reg    <= phase_next;
            fbc_reg      <= fbc_next;
            wb_reg       <= wb_next;
            off_reg      <= off_next;
            fs_reg       <= fs_next;
            slot_reg     <= slot_next;
            rs_reg       <= rs_next;
            pend_reg     <= pend_next;
            named_reg    <= named_next;
            nonempty_reg <= nonempty_next;
            halted_reg   <= halted_next;
        end
    end

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && in_last |=> phase_reg == PH_BOUND && pend_reg == 4'd0 &&
                              !halted_reg && off_reg == 32'd0)
        else $error("parser state not restarted after the last beat of a chunk");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && halted_reg |-> !push_valid)
        else $error("results produced after a chunk error");

    a_zeros_at_boundary: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg != 4'd0 |-> phase_reg == PH_BOUND)
        else $error("held zeros outside a record boundary");

endmodule

// ===== hw/rtl/rcsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record chunk parser result queue
// Short FIFO of result groups that decouples the parser from the serializer.
// ----------------------------------------------------------------------------
module rcsp_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  rcsp_pkg::group_t      push_group,
    output logic                  q_valid,
    input  logic                  q_pop,
    output rcsp_pkg::group_t      q_group
);

    rcsp_pkg::group_t           store_reg [rcsp_pkg::Q_DEPTH];
    logic [rcsp_pkg::Q_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rcsp_pkg::Q_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rcsp_pkg::Q_AW:0]    count_reg, count_next;
    logic                       do_push;
    logic                       do_pop;

    assign push_ready = (count_reg != (rcsp_pkg::Q_AW + 1)'(rcsp_pkg::Q_DEPTH));
    assign q_valid    = (count_reg != '0);
    assign q_group    = store_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + (rcsp_pkg::Q_AW)'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + (rcsp_pkg::Q_AW)'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (rcsp_pkg::Q_AW + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (rcsp_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            store_reg[wr_ptr_reg] <= push_group;
        end
    end

endmodule

// ===== hw/rtl/rcsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record chunk parser result serializer
// Walks the head group of the queue into the output register, one result per
// cycle while out_ready allows, and marks the final result of each group.
// ----------------------------------------------------------------------------
module rcsp_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  rcsp_pkg::group_t      q_group,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rcsp_pkg::result_t     out_res,
    output logic                  out_last
);

    logic [rcsp_pkg::RES_IDX_W-1:0] idx_reg, idx_next;
    logic                           valid_reg, valid_next;
    rcsp_pkg::result_t              res_reg;
    logic                           last_reg;
    logic                           load;
    logic                           grp_done;

    assign load     = q_valid && (!valid_reg || out_ready);
    assign grp_done = ({1'b0, idx_reg} + (rcsp_pkg::RES_CNT_W)'(1)) == q_group.cnt;
    assign q_pop    = load && grp_done;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = grp_done ? '0 : idx_reg + (rcsp_pkg::RES_IDX_W)'(1);
        end else if (out_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= q_group.res[idx_reg];
            last_reg <= grp_done;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

    a_group_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> q_group.cnt != '0)
        else $error("empty result group in the queue");

    a_index_in_group: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> ({1'b0, idx_reg} < q_group.cnt))
        else $error("result index beyond its group");

    a_group_held: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != '0 |-> q_valid)
        else $error("group left the queue before all its results were sent");

endmodule

// ===== hw/rtl/record_chunk_stream_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record chunk stream parser
// Parses a byte stream of records (marker, NUL-terminated name, count and
// parameter words) and reports each field plus one final verdict per chunk.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Beat contents
// -------  ---------  ---------------------------------------------------------
// s_       in         one chunk byte in s_tdata; s_tlast on the chunk's last byte
// m_       out        one result: kind in m_tuser, fields in m_tdata;
//                     m_tlast on the last result caused by one input byte
//
// Cycles: one input beat is taken per cycle while the result queue has room.
// Each beat causes zero to four results; the output side sends one result
// per cycle while m_tready is high, so the output port sets the sustained
// rate when beats produce several results. Results pass through the queue and
// the output register. Reset: aresetn is synchronous and active low; there is
// no clearing pass. Stalls: the four-group queue and the output register let
// either side stall without blocking the other until the queue fills.
//
// A record is a four byte little-endian marker, a name ended by a zero byte,
// a four byte little-endian count that must match the fixed parameter count,
// and that many little-endian 32-bit parameter words. Zero bytes seen at a
// record boundary are held back (up to nine); if the chunk ends on them they
// are padding, otherwise they are replayed as record bytes ahead of the
// nonzero byte that follows. The first error ends the chunk's results; the
// parser then drops bytes until the chunk's last beat, which always restarts
// it for the next chunk.
// ----------------------------------------------------------------------------
module record_chunk_stream_parser_top (
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // chunk_end

    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [31:0] word, [37:32] param_index,
                                    // [61:38] record_index, [64:62] error_code,
                                    // [96:65] error_offset, [97] likely_valid,
                                    // [103:98] zero
    output logic [2:0]   m_tuser,   // [2:0] kind
    output logic         m_tlast    // run_last
);

    logic                push_valid;
    logic                push_ready;
    rcsp_pkg::group_t    push_group;
    logic                q_valid;
    logic                q_pop;
    rcsp_pkg::group_t    q_group;
    rcsp_pkg::result_t   out_res;

    // Parser: classifies each byte and builds the group of results it causes.
    rcsp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group)
    );

    // Queue of result groups between parser and serializer.
    rcsp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_group (push_group),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_group    (q_group)
    );

    // Serializer: one result per output beat from a registered output stage.
    rcsp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_group   (q_group),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {6'd0,
                      out_res.likely_valid,
                      out_res.error_offset,
                      out_res.error_code,
                      out_res.record_index,
                      out_res.param_index,
                      out_res.word};

endmodule

// ===== tb/rcsp_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record chunk parser result checker
// Watches the byte channel and the result channel, runs its own copy of the
// record parser on every accepted byte and compares each result beat, field
// by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module rcsp_result_checker
    import rcsp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,

    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [7:0]   s_tdata,
    input  logic         s_tlast,

    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,

    output int           fail_count,
    output int           results_owed
);

    typedef enum logic [2:0] {
        AT_BOUNDARY,
        IN_MARKER,
        IN_NAME,
        IN_COUNT,
        IN_PARAMS
    } parse_phase_t;

    typedef struct packed {
        result_t res;
        logic    run_last;
    } result_beat_t;

    // Parser state as seen from the stream.
    parse_phase_t phase;
    logic [1:0]   nbytes;
    logic [31:0]  shift_word;
    logic [31:0]  offset;
    logic [31:0]  fstart;
    logic [5:0]   slot;
    logic [23:0]  nrecords;
    logic [3:0]   held_zeros;
    logic         names_ok;
    logic         name_seen;
    logic         stopped;

    // Results caused by the byte being parsed right now.
    result_t      group_res [MAX_RES];
    int           group_n;

    result_beat_t expected_results [$];
    int           mismatches = 0;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    task automatic restart_parser();
        phase      = AT_BOUNDARY;
        nbytes     = 2'd0;
        shift_word = 32'd0;
        offset     = 32'd0;
        fstart     = 32'd0;
        slot       = 6'd0;
        nrecords   = 24'd0;
        held_zeros = 4'd0;
        names_ok   = 1'b1;
        name_seen  = 1'b0;
        stopped    = 1'b0;
    endtask

    task automatic record_result(input kind_t kind, input logic [31:0] word,
                                 input logic [5:0] pidx, input err_t code,
                                 input logic [31:0] eoff, input logic likely);
        result_t r;
        r.kind         = kind;
        r.word         = word;
        r.param_index  = pidx;
        r.record_index = nrecords;
        r.error_code   = code;
        r.error_offset = eoff;
        r.likely_valid = likely;
        if (group_n < MAX_RES) begin
            group_res[group_n] = r;
            group_n++;
        end
    endtask

    task automatic report_error(input err_t code, input logic [31:0] off);
        record_result(KIND_ERROR, 32'd0, 6'd0, code, off, 1'b0);
        stopped = 1'b1;
    endtask

    // Advances the record parser by one byte that belongs to a record.
    task automatic parse_byte(input logic [7:0] b, input logic [31:0] off);
        logic [31:0] next_off;
        logic        full;
        next_off = sat_add(off, 32'd1);
        if (phase == AT_BOUNDARY) begin
            fstart = off;
            nbytes = 2'd0;
            phase  = IN_MARKER;
        end
        full = 1'b0;
        if (phase != IN_NAME) begin
            shift_word = {b, shift_word[31:8]};
            nbytes     = nbytes + 2'd1;
            full       = (nbytes == 2'd0);
        end
        case (phase)
            IN_MARKER: begin
                if (full) begin
                    record_result(KIND_MARKER, shift_word, 6'd0, ERR_NONE, 32'd0, 1'b0);
                    phase     = IN_NAME;
                    fstart    = next_off;
                    name_seen = 1'b0;
                end
            end
            IN_NAME: begin
                if (b != 8'd0) begin
                    name_seen = 1'b1;
                    record_result(KIND_NAME_BYTE, {24'd0, b}, 6'd0, ERR_NONE, 32'd0, 1'b0);
                end else begin
                    record_result(KIND_NAME_END, 32'd0, 6'd0, ERR_NONE, 32'd0, 1'b0);
                    if (!name_seen)
                        names_ok = 1'b0;
                    phase  = IN_COUNT;
                    fstart = next_off;
                    nbytes = 2'd0;
                end
            end
            IN_COUNT: begin
                if (full) begin
                    if (shift_word != COUNT_WORD) begin
                        report_error(ERR_WRONG_COUNT, fstart);
                    end else begin
                        phase  = IN_PARAMS;
                        slot   = 6'd0;
                        fstart = next_off;
                    end
                end
            end
            default: begin
                if (full) begin
                    record_result(KIND_PARAM, shift_word, slot, ERR_NONE, 32'd0, 1'b0);
                    fstart = next_off;
                    if (int'(slot) + 1 >= PARAM_COUNT) begin
                        if (nrecords < REC_MAX)
                            nrecords++;
                        slot  = 6'd0;
                        phase = AT_BOUNDARY;
                    end else begin
                        slot = slot + 6'd1;
                    end
                end
            end
        endcase
    endtask

    // Works out every result that one accepted chunk byte causes and queues them.
    task automatic predict_chunk_byte(input logic [7:0] b, input logic last);
        logic [31:0]  cur;
        logic [31:0]  base;
        int           cnt;
        int           k;
        result_beat_t nb;
        group_n = 0;
        cur     = offset;
        if (!stopped) begin
            offset = sat_add(offset, 32'd1);
            if (phase == AT_BOUNDARY && b == 8'd0) begin
                // Zeros at a record boundary wait until we know what follows.
                if (held_zeros == 4'd0)
                    fstart = cur;
                if (held_zeros < ZERO_SAT)
                    held_zeros++;
            end else begin
                if (phase == AT_BOUNDARY && held_zeros != 4'd0) begin
                    base       = fstart;
                    cnt        = int'(held_zeros);
                    held_zeros = 4'd0;
                    for (k = 0; k < cnt && !stopped; k++)
                        parse_byte(8'd0, sat_add(base, 32'(k)));
                end
                if (!stopped)
                    parse_byte(b, cur);
            end
            if (last && !stopped) begin
                case (phase)
                    AT_BOUNDARY: record_result(KIND_OK, 32'd0, 6'd0, ERR_NONE, 32'd0,
                                               (nrecords != 24'd0) && names_ok);
                    IN_MARKER:   report_error(ERR_MISSING_MARKER, fstart);
                    IN_NAME:     report_error(ERR_UNTERM_NAME, fstart);
                    IN_COUNT:    report_error(ERR_MISSING_COUNT, fstart);
                    default:     report_error(ERR_TRUNC_PARAMS, fstart);
                endcase
            end
        end
        for (k = 0; k < group_n; k++) begin
            nb.res           = group_res[k];
            nb.run_last      = (k == group_n - 1);
            expected_results = {expected_results, nb};
        end
        if (last)
            restart_parser();
    endtask

    task automatic check_result_beat();
        result_beat_t exp;
        if (expected_results.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: result beat kind %0d word %h with nothing expected",
                         $time, m_tuser, m_tdata[31:0]);
            mismatches++;
        end else begin
            exp = expected_results.pop_front();
            if (m_tuser !== exp.res.kind || m_tdata[31:0] !== exp.res.word ||
                m_tdata[37:32] !== exp.res.param_index ||
                m_tdata[61:38] !== exp.res.record_index ||
                m_tdata[64:62] !== exp.res.error_code ||
                m_tdata[96:65] !== exp.res.error_offset ||
                m_tdata[97] !== exp.res.likely_valid ||
                m_tdata[103:98] !== 6'd0 || m_tlast !== exp.run_last) begin
                if (mismatches < 10) begin
                    $display("%0t: expected kind %0d word %h pidx %0d rec %0d code %0d",
                             $time, exp.res.kind, exp.res.word, exp.res.param_index,
                             exp.res.record_index, exp.res.error_code);
                    $display("%0t: expected off %0d lv %b last %b",
                             $time, exp.res.error_offset, exp.res.likely_valid,
                             exp.run_last);
                    $display("%0t: actual   kind %0d word %h pidx %0d rec %0d code %0d",
                             $time, m_tuser, m_tdata[31:0], m_tdata[37:32],
                             m_tdata[61:38], m_tdata[64:62]);
                    $display("%0t: actual   off %0d lv %b last %b pad %h",
                             $time, m_tdata[96:65], m_tdata[97], m_tlast,
                             m_tdata[103:98]);
                end
                mismatches++;
            end
        end
    endtask

    // Results pass the queue and the output register after their byte, so the result
    // side is checked before the byte taken at the same edge adds its predictions.
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_parser();
            expected_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result_beat();
            if (s_tvalid && s_tready)
                predict_chunk_byte(s_tdata, s_tlast);
        end
        results_owed <= expected_results.size();
        fail_count   <= mismatches;
    end

endmodule

// ===== tb/record_chunk_stream_parser_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Record chunk stream parser testbench
// Feeds chunks of records, byte by byte, into the parser: a few hand-made
// chunks for the corner cases, then random chunks weighted toward well-formed
// ones, with broken, truncated and noisy ones mixed in. A checker beside the block
// predicts and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module record_chunk_stream_parser_top_tb;

    import rcsp_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_BYTES = 320;   // random bytes that the parser acts on
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES = 20;    // tail wait for stray result beats

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;

    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata  = 8'd0;
    logic         s_tlast  = 1'b0;

    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    int           fail_count;
    int           results_owed;

    // The whole byte stream is built up front: one byte and its end mark per beat.
    logic [7:0]   chunk_bytes  [$];
    bit           chunk_ends   [$];
    // Scratch area for one record before it is copied, whole or cut, into the stream.
    logic [7:0]   record_bytes [$];
    int           random_count = 0;

    logic [8:0]   ready_cycle  = 9'd0;
    int           idle_cycles  = 0;

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    record_chunk_stream_parser_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    rcsp_result_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    task automatic add_beat(input logic [7:0] b, input bit last);
        chunk_bytes = {chunk_bytes, b};
        chunk_ends  = {chunk_ends, last};
    endtask

    task automatic add_record_byte(input logic [7:0] b);
        record_bytes = {record_bytes, b};
    endtask

    // Builds one record in the scratch area. The marker bytes are sometimes zero
    // so that records open with zero runs that the parser must hold back and
    // replay. Parameter words follow only when the count is the right one.
    task automatic build_record(input int name_len, input logic [31:0] count_word);
        int          i;
        logic [31:0] pword;
        record_bytes.delete();
        for (i = 0; i < 4; i++)
            add_record_byte(($urandom_range(0, 4) == 0) ? 8'h00 : 8'($urandom));
        for (i = 0; i < name_len; i++)
            add_record_byte(8'($urandom_range(1, 255)));
        add_record_byte(8'h00);
        for (i = 0; i < 4; i++)
            add_record_byte(count_word[8*i +: 8]);
        if (count_word == COUNT_WORD) begin
            for (i = 0; i < PARAM_COUNT; i++) begin
                case ($urandom_range(0, 7))
                    0:       pword = 32'h0000_0000;
                    1:       pword = 32'hFFFF_FFFF;
                    default: pword = $urandom;
                endcase
                add_record_byte(pword[7:0]);
                add_record_byte(pword[15:8]);
                add_record_byte(pword[23:16]);
                add_record_byte(pword[31:24]);
            end
        end
    endtask

    // Copies the first n scratch bytes into the stream, optionally ending the chunk.
    task automatic copy_record(input int n, input bit end_chunk);
        int i;
        for (i = 0; i < n; i++)
            add_beat(record_bytes[i], end_chunk && (i == n - 1));
        random_count += n;
    endtask

    function automatic int pick_name_len();
        // Empty names are rare so that most successful chunks report likely_valid.
        return ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 5));
    endfunction

    // Receiver: cycles through four moods in turn, from always ready down to ready only
    // when the low three bits of its counter are zero, so that stalls land on every phase.
    always @(posedge aclk) begin
        ready_cycle <= ready_cycle + 9'd1;
        case (ready_cycle[8:7])
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= (ready_cycle[2:0] == 3'd0);
        endcase
    end

    // Watchdog: a run that stops moving on both channels has hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("record_chunk_stream_parser_top_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : drive_bytes
        int          idx;
        int          burst_left;
        int          gap;
        int          pick;
        int          nrec;
        int          pad;
        int          junk;
        int          i;
        logic [31:0] bad_count;

        // Directed chunks.
        // A lone zero byte is padding only: success with no records.
        add_beat(8'h00, 1'b1);
        // A lone byte that starts a marker it never finishes.
        add_beat(8'hFF, 1'b1);
        // A full marker, then the chunk ends inside the name.
        add_beat(8'h01, 1'b0);
        add_beat(8'h02, 1'b0);
        add_beat(8'h03, 1'b0);
        add_beat(8'h04, 1'b0);
        add_beat(8'h41, 1'b1);
        // Ten zeros saturate the held run at nine; replayed, they form a zero
        // marker, an empty name and a zero count, which is the wrong count.
        for (i = 0; i < 10; i++)
            add_beat(8'h00, 1'b0);
        add_beat(8'h80, 1'b1);
        // All-ones marker, empty name, and the count cut off after one byte.
        for (i = 0; i < 4; i++)
            add_beat(8'hFF, 1'b0);
        add_beat(8'h00, 1'b0);
        add_beat(8'h08, 1'b1);

        // Random chunks, weighted toward well-formed ones.
        while (random_count < RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                // One or two complete records, sometimes with zero padding.
                nrec = $urandom_range(1, 2);
                pad  = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 3));
                for (i = 0; i < nrec; i++) begin
                    build_record(pick_name_len(), COUNT_WORD);
                    copy_record(record_bytes.size(), (i == nrec - 1) && (pad == 0));
                end
                for (i = 0; i < pad; i++)
                    add_beat(8'h00, i == pad - 1);
                random_count += pad;
            end else if (pick < 70) begin
                // A record cut short anywhere, sometimes after a complete one.
                if ($urandom_range(0, 1) == 1) begin
                    build_record(pick_name_len(), COUNT_WORD);
                    copy_record(record_bytes.size(), 1'b0);
                end
                build_record(pick_name_len(), COUNT_WORD);
                copy_record($urandom_range(1, record_bytes.size() - 1), 1'b1);
            end else if (pick < 80) begin
                // A count that does not match; the bytes after it are dropped.
                if ($urandom_range(0, 1) == 1)
                    bad_count = COUNT_WORD ^ (32'd1 << $urandom_range(0, 31));
                else
                    bad_count = $urandom;
                if (bad_count == COUNT_WORD)
                    bad_count = 32'd0;
                build_record(pick_name_len(), bad_count);
                junk = $urandom_range(0, 3);
                copy_record(record_bytes.size(), junk == 0);
                for (i = 0; i < junk; i++)
                    add_beat(8'($urandom), i == junk - 1);
            end else if (pick < 88) begin
                // A zero run, ending the chunk or followed by one nonzero byte.
                pad = $urandom_range(1, 12);
                if ($urandom_range(0, 1) == 1) begin
                    for (i = 0; i < pad; i++)
                        add_beat(8'h00, i == pad - 1);
                end else begin
                    for (i = 0; i < pad; i++)
                        add_beat(8'h00, 1'b0);
                    add_beat(8'($urandom_range(1, 255)), 1'b1);
                    random_count += 1;
                end
                random_count += pad;
            end else begin
                // Noise: a few random bytes.
                pad = $urandom_range(1, 8);
                for (i = 0; i < pad; i++)
                    add_beat(8'($urandom), i == pad - 1);
                random_count += pad;
            end
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender: bursts of random length, mostly short, now and then long
        // stretches without a gap, with idle gaps of random length between them.
        burst_left = $urandom_range(1, 12);
        for (idx = 0; idx < chunk_bytes.size(); idx++) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
                burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(30, 60))
                                                          : int'($urandom_range(1, 12));
            end
            s_tvalid <= 1'b1;
            s_tdata  <= chunk_bytes[idx];
            s_tlast  <= chunk_ends[idx];
            @(posedge aclk);
            while (!s_tready)
                @(posedge aclk);
            burst_left--;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // A further clock edge lets the checker publish the predictions of the last beat;
        // the watchdog catches results that never come.
        @(posedge aclk);
        while (results_owed != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("record_chunk_stream_parser_top_tb OK");
        end else begin
            $display("record_chunk_stream_parser_top_tb NOT OK");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rcsp_pkg.sv
hw/rtl/rcsp_front.sv
hw/rtl/rcsp_queue.sv
hw/rtl/rcsp_back.sv
hw/rtl/record_chunk_stream_parser_top.sv
tb/rcsp_result_checker.sv
tb/record_chunk_stream_parser_top_tb.sv
